>>> design/flvec_pkg.sv
// ----------------------------------------------------------------------------
// flvec_pkg: shared types and constants for the fixed length direction vector
// widths of the datapaths, fixed-point constants, mode codes and the
// structs that travel down the cell chain
// ----------------------------------------------------------------------------
`default_nettype none

package flvec_pkg;

   localparam int DIR_W      = 32;   // dir_x / dir_y
   localparam int LEN_W      = 32;   // length
   localparam int OUT_W      = 33;   // offset_x / offset_y
   localparam int MAG_W      = 33;   // magnitude of a direction component
   localparam int VW         = 36;   // vectoring datapath, signed
   localparam int PW         = 44;   // rotation datapath with guard bits, signed
   localparam int PROD_W     = 64;
   localparam int GUARD_BITS = 8;

   // sqrt(2)/2 and the cordic gain inverse, both Q0.32
   localparam logic [31:0] RT2O2_Q32 = 32'hB504F334;
   localparam logic [31:0] KINV_Q32  = 32'h9B74EDA8;
   localparam logic [31:0] MAG_MAX   = 32'hFFFFFFFF;

   typedef enum logic [2:0] {
      MODE_ZERO,     // both components zero
      MODE_X_ZERO,   // x zero, length goes on y
      MODE_Y_ZERO,   // y zero, length goes on x
      MODE_DIAG,     // equal magnitudes
      MODE_ROT       // general case, cordic
   } flvec_mode_type;

   typedef struct packed {
      flvec_mode_type mode;
      logic           neg_x;
      logic           neg_y;
   } flvec_side_type;

   typedef struct packed {
      logic signed [VW-1:0] vx;
      logic signed [VW-1:0] vy;
      logic signed [PW-1:0] px;
      logic signed [PW-1:0] py;
   } flvec_vec_type;

endpackage

`default_nettype wire

>>> design/flvec_prep.sv
// ----------------------------------------------------------------------------
// flvec_prep: input classification and gain multiply
// two registered stages: sort out the special cases and fold to the first
// quadrant, then scale the length by the gain inverse or by sqrt(2)/2
// ----------------------------------------------------------------------------
`default_nettype none

module flvec_prep
   import flvec_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    advance,
   input  wire logic                    in_valid,
   input  wire logic signed [DIR_W-1:0] dir_x,
   input  wire logic signed [DIR_W-1:0] dir_y,
   input  wire logic        [LEN_W-1:0] length,
   output      logic                    prep_valid,
   output      flvec_side_type          prep_side,
   output      flvec_vec_type           prep_vec
);

   // stage a
   logic                 a_valid_ff;
   flvec_side_type       a_side_ff, a_side_in;
   logic [MAG_W-1:0]     a_ax_ff, a_ax_in;
   logic [MAG_W-1:0]     a_ay_ff, a_ay_in;
   logic [LEN_W-1:0]     a_len_ff;

   // stage b
   logic                 b_valid_ff;
   flvec_side_type       b_side_ff;
   flvec_vec_type        b_vec_ff, b_vec_in;

   logic [31:0]          mult_k;
   logic [PROD_W-1:0]    prod;

   // absolute values, 33 bits so that the most negative input folds cleanly
   always_comb begin
      a_ax_in = dir_x[DIR_W-1] ? (MAG_W'(0) - {dir_x[DIR_W-1], dir_x})
                               : {1'b0, dir_x};
      a_ay_in = dir_y[DIR_W-1] ? (MAG_W'(0) - {dir_y[DIR_W-1], dir_y})
                               : {1'b0, dir_y};
      a_side_in.neg_x = dir_x[DIR_W-1];
      a_side_in.neg_y = dir_y[DIR_W-1];
      if (dir_x == '0 && dir_y == '0) begin
         a_side_in.mode = MODE_ZERO;
      end else if (dir_x == '0) begin
         a_side_in.mode = MODE_X_ZERO;
      end else if (dir_y == '0) begin
         a_side_in.mode = MODE_Y_ZERO;
      end else if (a_ax_in == a_ay_in) begin
         a_side_in.mode = MODE_DIAG;
      end else begin
         a_side_in.mode = MODE_ROT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_side_ff <= a_side_in;
         a_ax_ff   <= a_ax_in;
         a_ay_ff   <= a_ay_in;
         a_len_ff  <= length;
      end
   end

   // one shared multiplier, constant picked by mode
   assign mult_k = (a_side_ff.mode == MODE_DIAG) ? RT2O2_Q32 : KINV_Q32;
   assign prod   = PROD_W'(a_len_ff) * PROD_W'(mult_k);

   always_comb begin
      b_vec_in.vx = $signed({{(VW-MAG_W){1'b0}}, a_ax_ff});
      b_vec_in.vy = $signed({{(VW-MAG_W){1'b0}}, a_ay_ff});
      b_vec_in.py = '0;
      case (a_side_ff.mode)
         MODE_X_ZERO, MODE_Y_ZERO: begin
            b_vec_in.px = $signed({{(PW-LEN_W){1'b0}}, a_len_ff});
         end
         MODE_DIAG: begin
            b_vec_in.px = $signed({{(PW-32){1'b0}}, prod[PROD_W-1:32]});
         end
         default: begin
            // length * kinv with guard bits kept
            b_vec_in.px = $signed({{(PW-40){1'b0}}, prod[PROD_W-1:32-GUARD_BITS]});
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_side_ff <= a_side_ff;
         b_vec_ff  <= b_vec_in;
      end
   end

   assign prep_valid = b_valid_ff;
   assign prep_side  = b_side_ff;
   assign prep_vec   = b_vec_ff;

endmodule

`default_nettype wire

>>> design/flvec_cell.sv
// ----------------------------------------------------------------------------
// flvec_cell: one cordic micro-rotation
// in rotate mode, steers the vectoring pair toward the x axis and turns the
// rotation pair the opposite way by the same step, then registers both
// ----------------------------------------------------------------------------
`default_nettype none

module flvec_cell
   import flvec_pkg::*;
#(
   parameter int SHIFT = 0
)
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           advance,
   input  wire logic           prev_valid,
   input  wire flvec_side_type prev_side,
   input  wire flvec_vec_type  prev_vec,
   output      logic           cell_valid,
   output      flvec_side_type cell_side,
   output      flvec_vec_type  cell_vec
);

   logic                 valid_ff;
   flvec_side_type       side_ff;
   flvec_vec_type        vec_ff, vec_in;
   logic signed [VW-1:0] svx, svy;
   logic signed [PW-1:0] spx, spy;

   assign svx = $signed(prev_vec.vx) >>> SHIFT;
   assign svy = $signed(prev_vec.vy) >>> SHIFT;
   assign spx = $signed(prev_vec.px) >>> SHIFT;
   assign spy = $signed(prev_vec.py) >>> SHIFT;

   always_comb begin
      vec_in = prev_vec;
      if (prev_side.mode == MODE_ROT) begin
         if (!prev_vec.vy[VW-1]) begin
            vec_in.vx = prev_vec.vx + svy;
            vec_in.vy = prev_vec.vy - svx;
            vec_in.px = prev_vec.px - spy;
            vec_in.py = prev_vec.py + spx;
         end else begin
            vec_in.vx = prev_vec.vx - svy;
            vec_in.vy = prev_vec.vy + svx;
            vec_in.px = prev_vec.px + spy;
            vec_in.py = prev_vec.py - spx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff <= prev_side;
         vec_ff  <= vec_in;
      end
   end

   assign cell_valid = valid_ff;
   assign cell_side  = side_ff;
   assign cell_vec   = vec_ff;

endmodule

`default_nettype wire

>>> design/flvec_post.sv
// ----------------------------------------------------------------------------
// flvec_post: result assembly
// drops the guard bits toward zero, saturates, picks the special-case
// results and restores the quadrant signs
// ----------------------------------------------------------------------------
`default_nettype none

module flvec_post
   import flvec_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    advance,
   input  wire logic                    prev_valid,
   input  wire flvec_side_type          prev_side,
   input  wire flvec_vec_type           prev_vec,
   output      logic                    post_valid,
   output      logic signed [OUT_W-1:0] post_x,
   output      logic signed [OUT_W-1:0] post_y
);

   logic                    valid_ff;
   logic signed [OUT_W-1:0] x_ff, x_in;
   logic signed [OUT_W-1:0] y_ff, y_in;
   logic signed [OUT_W-1:0] rx, ry;
   logic signed [OUT_W-1:0] plain;

   // magnitude >> guard, saturated, sign of the value kept
   function automatic logic signed [OUT_W-1:0] guard_trunc(
      input logic signed [PW-1:0] v
   );
      logic [PW-1:0]            mag;
      logic [PW-GUARD_BITS-1:0] sh;
      logic [31:0]              m;
      mag = v[PW-1] ? (PW'(0) - v) : v;
      sh  = mag[PW-1:GUARD_BITS];
      m   = (|sh[PW-GUARD_BITS-1:32]) ? MAG_MAX : sh[31:0];
      return v[PW-1] ? (OUT_W'(0) - {1'b0, m}) : $signed({1'b0, m});
   endfunction

   assign plain = $signed({1'b0, prev_vec.px[31:0]});

   always_comb begin
      case (prev_side.mode)
         MODE_ZERO: begin
            rx = '0;
            ry = '0;
         end
         MODE_X_ZERO: begin
            rx = '0;
            ry = plain;
         end
         MODE_Y_ZERO: begin
            rx = plain;
            ry = '0;
         end
         MODE_DIAG: begin
            rx = plain;
            ry = plain;
         end
         default: begin
            rx = guard_trunc(prev_vec.px);
            ry = guard_trunc(prev_vec.py);
         end
      endcase
      x_in = prev_side.neg_x ? (OUT_W'(0) - rx) : rx;
      y_in = prev_side.neg_y ? (OUT_W'(0) - ry) : ry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff <= x_in;
         y_ff <= y_in;
      end
   end

   assign post_valid = valid_ff;
   assign post_x     = x_ff;
   assign post_y     = y_ff;

endmodule

`default_nettype wire

>>> design/fixed_length_direction_vector.sv
// ----------------------------------------------------------------------------
// fixed_length_direction_vector: scale a direction to a given length
// turns a signed Q16.16 direction and an unsigned Q16.16 length into the
// signed Q17.16 offset of that length along the direction, via cordic
// ----------------------------------------------------------------------------
// One word in, one word out, every cycle while the skid entry is empty. Each
// word passes the prep registers (input classification, gain multiply), one
// cell per cordic micro-rotation in a row of CORDIC_STAGES cells, the post
// register (guard bits off, signs restored) and the output register before
// rsp_tvalid. Zero and axis-aligned directions are exact, diagonals are
// scaled by sqrt(2)/2; all others go through the cells. Results are rounded
// toward zero and the magnitude saturates at 2^32-1. A two-entry output
// buffer keeps req_tready high while one finished word waits on rsp_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_length_direction_vector
   import flvec_pkg::*;
#(
   parameter int CORDIC_STAGES = 20
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   // input words
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [95:0] req_tdata,   // dir_x [31:0], dir_y [63:32], length [95:64]
   // result words
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [71:0] rsp_tdata    // offset_x [32:0], offset_y [65:33], zero above
);

   localparam int RSP_W = 2 * OUT_W;

   // whole pipeline moves together, held only while the skid entry is full
   logic advance;

   // chain of cells, slot 0 is the prep output
   logic           chain_valid [CORDIC_STAGES+1];
   flvec_side_type chain_side  [CORDIC_STAGES+1];
   flvec_vec_type  chain_vec   [CORDIC_STAGES+1];

   logic                    post_valid;
   logic signed [OUT_W-1:0] post_x, post_y;
   logic [RSP_W-1:0]        post_data;

   // output register plus skid entry
   logic             rsp_vld_ff;
   logic [RSP_W-1:0] rsp_data_ff;
   logic             skid_vld_ff;
   logic [RSP_W-1:0] skid_data_ff;

   assign advance    = !skid_vld_ff;
   assign req_tready = advance;

   // classify, fold, and scale the length
   flvec_prep u_prep (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (req_tvalid),
      .dir_x      ($signed(req_tdata[31:0])),
      .dir_y      ($signed(req_tdata[63:32])),
      .length     (req_tdata[95:64]),
      .prep_valid (chain_valid[0]),
      .prep_side  (chain_side[0]),
      .prep_vec   (chain_vec[0])
   );

   // cell k shifts by k
   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
      flvec_cell #(
         .SHIFT (k)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .prev_valid (chain_valid[k]),
         .prev_side  (chain_side[k]),
         .prev_vec   (chain_vec[k]),
         .cell_valid (chain_valid[k+1]),
         .cell_side  (chain_side[k+1]),
         .cell_vec   (chain_vec[k+1])
      );
   end

   // guard bits off, signs back
   flvec_post u_post (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .prev_valid (chain_valid[CORDIC_STAGES]),
      .prev_side  (chain_side[CORDIC_STAGES]),
      .prev_vec   (chain_vec[CORDIC_STAGES]),
      .post_valid (post_valid),
      .post_x     (post_x),
      .post_y     (post_y)
   );

   assign post_data = {post_y, post_x};

   // output register refills from skid first; skid catches the word that
   // arrives while the output register is stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (rsp_tready || !rsp_vld_ff) begin
         rsp_vld_ff  <= skid_vld_ff || post_valid;
         skid_vld_ff <= 1'b0;
      end else if (post_valid && advance) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_tready || !rsp_vld_ff) begin
         rsp_data_ff <= skid_vld_ff ? skid_data_ff : post_data;
      end else if (post_valid && advance) begin
         skid_data_ff <= post_data;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {{(72-RSP_W){1'b0}}, rsp_data_ff};

   // skid entry only ever holds a word behind a waiting output word
   a_skid_behind_out: assert property (
      @(posedge clock) disable iff (reset) skid_vld_ff |-> rsp_vld_ff
   ) else $error("skid entry full while output register empty");

   // skid fills only when the output word was stalled
   a_skid_fill_on_stall: assert property (
      @(posedge clock) disable iff (reset)
      $rose(skid_vld_ff) |-> $past(rsp_vld_ff && !rsp_tready && post_valid)
   ) else $error("skid entry filled without a stalled output");

   // a finished word at the tail is not dropped while the pipeline holds
   a_tail_held: assert property (
      @(posedge clock) disable iff (reset)
      (post_valid && !advance) |=> (post_valid && $stable(post_data))
   ) else $error("tail word changed during a stall");

   // full skid releases as soon as the output word is taken
   a_skid_drains: assert property (
      @(posedge clock) disable iff (reset)
      (skid_vld_ff && rsp_tready) |=> (!skid_vld_ff && rsp_vld_ff)
   ) else $error("skid entry did not drain into the output register");

endmodule

`default_nettype wire
